// ===== design/brq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brq_pkg: shared types, constants and helper functions
// Operation codes, word geometry and the small bit helpers used by the
// range query datapath.
// ----------------------------------------------------------------------------
package brq_pkg;

   // Word geometry of the stored bit vector.
   localparam int WORD_BITS = 64;
   localparam int BIT_SEL_W = 6;
   localparam int POS_W     = 13;

   // Operation codes of a request beat.
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_BUILD = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Mask with the low n bits set; n of 64 or more gives all ones.
   function automatic logic [WORD_BITS-1:0] low_ones(input logic [6:0] n);
      logic [WORD_BITS-1:0] m;
      if (n >= 7'd64) begin
         m = '1;
      end else begin
         m = (64'd1 << n) - 64'd1;
      end
      return m;
   endfunction

   // Position of the highest set bit; zero for an input of zero or one.
   function automatic logic [2:0] floor_log2_8(input logic [7:0] v);
      logic [2:0] r;
      r = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (v[i]) begin
            r = 3'(i);
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/brq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brq_ram: one write port, two registered read ports
// Plain synchronous memory used for the word store and the summary table.
// ----------------------------------------------------------------------------
module brq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_a_ff,
   output logic      [WIDTH-1:0] rd_data_b_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Two read ports with registered data.
   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

endmodule
`default_nettype wire

// ===== design/bit_range_any_set_query.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bit_range_any_set_query: range OR query over a stored bit vector
// Holds MAX_WORDS words of 64 bits and a table of OR summaries over windows
// of 2^(k+1) words. A small sequencer drives one OR/compare unit and two
// dual-read memories through word writes, summary builds and queries.
//
//   Channel | Direction | Handshake           | Payload
//   req     | in        | req_valid/req_ready | operation, word_index, word_data,
//           |           |                     | lo, hi
//   rsp     | out       | rsp_valid/rsp_ready | any_set, range_error
//   csr     | in        | csr_wr_en           | csr_wr_data (num_bits)
//
// A write, an unused operation, an error or an empty query goes straight to
// S_FIN, a one-word query through S_Q1 and any other query through S_Q1 and
// S_Q2, paced by the registered memory reads. A build writes one summary
// entry per cycle through the table read/modify/write port, level by level.
// After reset a clearing pass zeroes both memories; req_ready stays low
// meanwhile. A result waiting on rsp_ready holds the sequencer in its final
// state until the output register frees up.
// ----------------------------------------------------------------------------
module bit_range_any_set_query
   import brq_pkg::*;
#(
   parameter int MAX_WORDS = 64,
   parameter int LEVELS    = 6
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_operation,
   input  wire logic [5:0]           req_word_index,
   input  wire logic [WORD_BITS-1:0] req_word_data,
   input  wire logic [POS_W-1:0]     req_lo,
   input  wire logic [POS_W-1:0]     req_hi,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_any_set,
   output logic                      rsp_range_error,
   input  wire logic                 csr_wr_en,
   input  wire logic [POS_W-1:0]     csr_wr_data
);

   localparam int AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int LVW   = $clog2(LEVELS);
   localparam int XW    = ((AW > 10) ? AW : 10) + 2;
   localparam int CAPW  = $clog2(MAX_WORDS * WORD_BITS + 1);
   localparam int EW    = (CAPW > POS_W) ? CAPW : POS_W;
   localparam int CAP   = MAX_WORDS * WORD_BITS;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_Q1     = 7'b0000100,
      S_Q2     = 7'b0001000,
      S_BUILD  = 7'b0010000,
      S_BDRAIN = 7'b0100000,
      S_FIN    = 7'b1000000
   } state_type;

   // Clamp a wide index to a memory address; out-of-range reads go to 0.
   function automatic logic [AW-1:0] to_addr(input logic [XW-1:0] v);
      logic [AW-1:0] a;
      if (v < XW'(MAX_WORDS)) begin
         a = v[AW-1:0];
      end else begin
         a = '0;
      end
      return a;
   endfunction

   state_type          state_ff, state_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic [LVW-1:0]     lev_ff, lev_in;
   logic [POS_W-1:0]   num_bits_ff;
   logic [POS_W-1:0]   lo_ff, lo_in;
   logic [POS_W-1:0]   hi_ff, hi_in;
   logic               acc_ff, acc_in;
   logic               mid_word_ff, mid_word_in;
   logic               mid_sum_ff, mid_sum_in;
   logic [2:0]         qlev_ff, qlev_in;
   logic               res_any_ff, res_any_in;
   logic               res_err_ff, res_err_in;
   logic               bld_wr_ff, bld_wr_in;
   logic [AW-1:0]      bld_j_ff;
   logic [LVW-1:0]     bld_k_ff;
   logic               bld_ok_ff, bld_ok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_any_ff;
   logic               rsp_err_ff;

   logic                 word_we;
   logic [AW-1:0]        word_waddr;
   logic [WORD_BITS-1:0] word_wdata;
   logic [AW-1:0]        word_raddr_a, word_raddr_b;
   logic [WORD_BITS-1:0] word_rdata_a, word_rdata_b;
   logic                 sum_we;
   logic [AW-1:0]        sum_waddr;
   logic [LEVELS-1:0]    sum_wdata;
   logic [AW-1:0]        sum_raddr_a, sum_raddr_b;
   logic [LEVELS-1:0]    sum_rdata_a, sum_rdata_b;

   logic               req_fire;
   logic               rsp_load;
   logic               q_err, q_empty;
   logic [7:0]         lw, hw;
   logic [5:0]         lb, hb;
   logic               q_single;
   logic [POS_W-1:0]   q_len;
   logic [WORD_BITS-1:0] lo_part, hi_part;
   logic               single_hit;
   logic [7:0]         mid_n;
   logic [2:0]         lg;
   logic [7:0]         pos2;
   logic [LEVELS-1:0]  sa_sh, sb_sh;
   logic               mid_hit;
   logic [XW-1:0]      words_x, nb_words, b_x, end_x;
   logic [LEVELS-1:0]  prev_a_sh, prev_b_sh;
   logic               bld_bit;

   assign req_fire = req_valid && req_ready;
   assign rsp_load = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   // Word store and summary table.
   brq_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_WORDS), .AW(AW)) u_word_ram (
      .clock        (clock),
      .wr_en        (word_we),
      .wr_addr      (word_waddr),
      .wr_data      (word_wdata),
      .rd_addr_a    (word_raddr_a),
      .rd_addr_b    (word_raddr_b),
      .rd_data_a_ff (word_rdata_a),
      .rd_data_b_ff (word_rdata_b)
   );

   brq_ram #(.WIDTH(LEVELS), .DEPTH(MAX_WORDS), .AW(AW)) u_sum_ram (
      .clock        (clock),
      .wr_en        (sum_we),
      .wr_addr      (sum_waddr),
      .wr_data      (sum_wdata),
      .rd_addr_a    (sum_raddr_a),
      .rd_addr_b    (sum_raddr_b),
      .rd_data_a_ff (sum_rdata_a),
      .rd_data_b_ff (sum_rdata_b)
   );

   // Checks made on the incoming query beat.
   always_comb begin
      q_err   = (req_hi > num_bits_ff) || (EW'(req_hi) > EW'(CAP));
      q_empty = (req_hi <= req_lo);
   end

   // Query decode from the latched range.
   always_comb begin
      lw       = {1'b0, lo_ff[POS_W-1:BIT_SEL_W]};
      hw       = {1'b0, hi_ff[POS_W-1:BIT_SEL_W]};
      lb       = lo_ff[BIT_SEL_W-1:0];
      hb       = hi_ff[BIT_SEL_W-1:0];
      q_single = ({lo_ff[POS_W-1:BIT_SEL_W], 6'h3f}) >= (hi_ff - 13'd1);
      q_len    = hi_ff - lo_ff;
      lo_part  = word_rdata_a >> lb;
      if ((hb != 6'd0) && (XW'(hw) < XW'(MAX_WORDS))) begin
         hi_part = word_rdata_b & low_ones({1'b0, hb});
      end else begin
         hi_part = '0;
      end
      single_hit = |(lo_part & low_ones(q_len[6:0]));
      mid_n      = hw - lw - 8'd1;
      lg         = floor_log2_8(mid_n);
      pos2       = hw - (8'd1 << lg);
      sa_sh      = sum_rdata_a >> qlev_ff;
      sb_sh      = sum_rdata_b >> qlev_ff;
      mid_hit    = (mid_word_ff && (|word_rdata_a)) ||
                   (mid_sum_ff && (sa_sh[0] || sb_sh[0]));
   end

   // Build window geometry: words summarized and the partner index.
   always_comb begin
      nb_words = XW'(num_bits_ff[POS_W-1:BIT_SEL_W]);
      if (nb_words > XW'(MAX_WORDS)) begin
         words_x = XW'(MAX_WORDS);
      end else begin
         words_x = nb_words;
      end
      b_x   = XW'(cnt_ff) + (XW'(1) << lev_ff);
      end_x = XW'(cnt_ff) + (XW'(1) << ({1'b0, lev_ff} + 1'b1));
   end

   // Summary bit of one build step, from the registered reads issued in the previous cycle.
   always_comb begin
      prev_a_sh = sum_rdata_a >> (bld_k_ff - 1'b1);
      prev_b_sh = sum_rdata_b >> (bld_k_ff - 1'b1);
      if (bld_k_ff == '0) begin
         bld_bit   = ((|word_rdata_a) || (|word_rdata_b)) && bld_ok_ff;
         sum_wdata = LEVELS'(bld_bit);
      end else begin
         bld_bit   = (prev_a_sh[0] || prev_b_sh[0]) && bld_ok_ff;
         sum_wdata = sum_rdata_a | (LEVELS'(bld_bit) << bld_k_ff);
      end
      if (state_ff == S_CLEAR) begin
         sum_wdata = '0;
      end
   end

   // Memory port steering.
   always_comb begin
      word_we      = 1'b0;
      word_waddr   = cnt_ff;
      word_wdata   = '0;
      word_raddr_a = '0;
      word_raddr_b = '0;
      sum_we       = bld_wr_ff;
      sum_waddr    = bld_j_ff;
      sum_raddr_a  = '0;
      sum_raddr_b  = '0;
      case (state_ff)
         S_CLEAR: begin
            word_we = 1'b1;
            sum_we  = 1'b1;
            sum_waddr = cnt_ff;
         end
         S_IDLE: begin
            word_we      = req_fire && (op_type'(req_operation) == OP_WRITE) &&
                           (XW'(req_word_index) < XW'(MAX_WORDS));
            word_waddr   = to_addr(XW'(req_word_index));
            word_wdata   = req_word_data;
            word_raddr_a = to_addr(XW'(req_lo[POS_W-1:BIT_SEL_W]));
            word_raddr_b = to_addr(XW'(req_hi[POS_W-1:BIT_SEL_W]));
         end
         S_Q1: begin
            word_raddr_a = to_addr(XW'(lw + 8'd1));
            sum_raddr_a  = to_addr(XW'(lw + 8'd1));
            sum_raddr_b  = to_addr(XW'(pos2));
         end
         S_BUILD: begin
            word_raddr_a = cnt_ff;
            word_raddr_b = to_addr(b_x);
            sum_raddr_a  = cnt_ff;
            sum_raddr_b  = to_addr(b_x);
         end
         default: begin
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      lev_in      = lev_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      acc_in      = acc_ff;
      mid_word_in = mid_word_ff;
      mid_sum_in  = mid_sum_ff;
      qlev_in     = qlev_ff;
      res_any_in  = res_any_ff;
      res_err_in  = res_err_ff;
      bld_wr_in   = 1'b0;
      bld_ok_in   = (end_x <= words_x);
      case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == AW'(MAX_WORDS - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               res_any_in = 1'b0;
               res_err_in = 1'b0;
               lo_in      = req_lo;
               hi_in      = req_hi;
               state_in   = S_FIN;
               case (op_type'(req_operation))
                  OP_BUILD: begin
                     cnt_in   = '0;
                     lev_in   = '0;
                     state_in = S_BUILD;
                  end
                  OP_QUERY: begin
                     if (q_err) begin
                        res_err_in = 1'b1;
                     end else if (q_empty) begin
                        res_any_in = 1'b1;
                     end else begin
                        state_in = S_Q1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_Q1: begin
            if (q_single) begin
               res_any_in = single_hit;
               state_in   = S_FIN;
            end else begin
               acc_in      = |(lo_part | hi_part);
               mid_word_in = (lw + 8'd2 == hw);
               mid_sum_in  = (lw + 8'd2 < hw);
               qlev_in     = lg - 3'd1;
               state_in    = S_Q2;
            end
         end
         S_Q2: begin
            res_any_in = acc_ff || mid_hit;
            state_in   = S_FIN;
         end
         S_BUILD: begin
            bld_wr_in = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == AW'(MAX_WORDS - 1)) begin
               cnt_in = '0;
               if (lev_ff == LVW'(LEVELS - 1)) begin
                  state_in = S_BDRAIN;
               end else begin
                  lev_in = lev_ff + 1'b1;
               end
            end
         end
         S_BDRAIN: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   // Output register valid flag.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         lev_ff       <= '0;
         bld_wr_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         num_bits_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         lev_ff       <= lev_in;
         bld_wr_ff    <= bld_wr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            num_bits_ff <= csr_wr_data;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      acc_ff      <= acc_in;
      mid_word_ff <= mid_word_in;
      mid_sum_ff  <= mid_sum_in;
      qlev_ff     <= qlev_in;
      res_any_ff  <= res_any_in;
      res_err_ff  <= res_err_in;
      bld_j_ff    <= cnt_ff;
      bld_k_ff    <= lev_ff;
      bld_ok_ff   <= bld_ok_in;
      if (rsp_load) begin
         rsp_any_ff <= res_any_ff;
         rsp_err_ff <= res_err_ff;
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_any_set     = rsp_any_ff;
   assign rsp_range_error = rsp_err_ff;

`ifndef SYNTHESIS
   // An accepted beat always leaves the sequencer busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted back to back");

   // An error result never reports a hit.
   a_err_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_any_set && rsp_range_error))
      else $error("range error with any_set high");

   // The word store is written only by the clearing pass or a write beat.
   a_word_we_src: assert property (@(posedge clock) disable iff (reset)
      word_we |-> ((state_ff == S_CLEAR) ||
                   (req_fire && (op_type'(req_operation) == OP_WRITE))))
      else $error("unexpected word store write");

   // Summary writes come only from the clearing pass or a build step.
   a_sum_we_src: assert property (@(posedge clock) disable iff (reset)
      sum_we |-> ((state_ff == S_CLEAR) || $past(state_ff == S_BUILD)))
      else $error("unexpected summary write");
`endif

endmodule
`default_nettype wire
